// ===== rtl/nrbp_pkg.sv =====
// Package for the nearest ray/box pick unit.
// Holds the payload structs, fixed-point widths and register indexes.
// No dependencies.
package nrbp_pkg;

   localparam int COORD_W   = 32;
   localparam int TAG_W     = 16;
   localparam int FRAC_W    = 16;
   localparam int DIST_W    = COORD_W - 1;
   localparam int CSR_IDX_W = 3;
   localparam int CNT_W     = $clog2(COORD_W);
   localparam int MAG_W     = COORD_W + 2;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = CSR_IDX_W'(5);

   typedef struct packed {
      logic signed [COORD_W-1:0] box_center_x;
      logic signed [COORD_W-1:0] box_center_y;
      logic signed [COORD_W-1:0] box_center_z;
      logic signed [COORD_W-1:0] box_size_x;
      logic signed [COORD_W-1:0] box_size_y;
      logic signed [COORD_W-1:0] box_size_z;
      logic [TAG_W-1:0]          selection_tag;
      logic                      last_box;
   } nrbp_box_type;

   typedef struct packed {
      logic              hit_found;
      logic [TAG_W-1:0]  nearest_tag;
      logic [DIST_W-1:0] nearest_distance;
   } nrbp_pick_type;

endpackage

// ===== rtl/nearest_ray_box_pick_unit.sv =====
// Nearest ray/box pick unit: slab test of a box stream against a ray, keeps nearest hit.
// Uses nrbp_pkg for payload types, widths and register indexes.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  nrbp_box_type, one box per transfer
//   rsp      out        rsp_valid / rsp_stall  nrbp_pick_type, one per last box
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A box is accepted in ST_IDLE, and req_stall holds off the next box until the unit is back
// in ST_IDLE. Up to six slab divisions run through one shared restoring divider, and the box
// is closed in ST_FINISH; a parallel axis skips its two divisions, a saturating quotient
// skips its 32 divide steps, and a box with a non-positive size goes straight to ST_FINISH.
// Reset is synchronous; it clears the ray registers and the running best.
// The result register lets the next box start while a result waits under rsp_stall.
module nearest_ray_box_pick_unit
   import nrbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  nrbp_box_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output nrbp_pick_type        rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_AXIS   = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   nrbp_box_type              box_ff, box_in;
   logic [1:0]                axis_ff, axis_in;
   logic                      side_ff, side_in;
   logic                      miss_ff, miss_in;
   logic signed [COORD_W-1:0] tmin_ff, tmin_in;
   logic signed [COORD_W-1:0] tmax_ff, tmax_in;
   logic signed [COORD_W-1:0] tfirst_ff, tfirst_in;
   logic [COORD_W-1:0]        rem_ff, rem_in;
   logic [COORD_W-1:0]        quo_ff, quo_in;
   logic [COORD_W-1:0]        dmag_ff, dmag_in;
   logic                      neg_ff, neg_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [COORD_W-1:0] best_dist_ff, best_dist_in;
   logic [TAG_W-1:0]          best_tag_ff, best_tag_in;
   logic                      best_valid_ff, best_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   nrbp_pick_type             rsp_data_ff, rsp_data_in;
   logic signed [COORD_W-1:0] origin_ff [3];
   logic signed [COORD_W-1:0] origin_in [3];
   logic signed [COORD_W-1:0] dir_ff [3];
   logic signed [COORD_W-1:0] dir_in [3];

   logic signed [COORD_W-1:0] cen, size, org, dir, half, t_sat, t_lo, t_hi;
   logic signed [COORD_W+1:0] lo, hi, org_ext;
   logic signed [COORD_W+2:0] diff, diff_neg;
   logic [MAG_W-1:0]          diff_mag;
   logic [COORD_W-1:0]        rem_start, num_low, dir_mag;
   logic [COORD_W:0]          dir_neg;
   logic [COORD_W+1:0]        trial;
   logic                      trial_ok, overflow, sizes_bad, outside, last_axis;
   logic                      hit, take;
   logic signed [COORD_W-1:0] nb_dist;
   logic [TAG_W-1:0]          nb_tag;
   logic                      nb_valid;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            cen  = box_ff.box_center_x;
            size = box_ff.box_size_x;
         end
         2'd1: begin
            cen  = box_ff.box_center_y;
            size = box_ff.box_size_y;
         end
         default: begin
            cen  = box_ff.box_center_z;
            size = box_ff.box_size_z;
         end
      endcase
      org = origin_ff[axis_ff];
      dir = dir_ff[axis_ff];

      sizes_bad = (box_ff.box_size_x <= 0) || (box_ff.box_size_y <= 0) ||
                  (box_ff.box_size_z <= 0);
      half      = size >>> 1;
      lo        = {{2{cen[COORD_W-1]}}, cen} - {{2{half[COORD_W-1]}}, half};
      hi        = {{2{cen[COORD_W-1]}}, cen} + {{2{half[COORD_W-1]}}, half};
      org_ext   = {{2{org[COORD_W-1]}}, org};
      outside   = (org_ext < lo) || (org_ext > hi);
      last_axis = (axis_ff == 2'd2);

      diff      = side_ff ? ({hi[COORD_W+1], hi} - {{3{org[COORD_W-1]}}, org})
                          : ({lo[COORD_W+1], lo} - {{3{org[COORD_W-1]}}, org});
      diff_neg  = -diff;
      diff_mag  = diff[COORD_W+2] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
      rem_start = {{(COORD_W-(MAG_W-(COORD_W-FRAC_W))){1'b0}},
                   diff_mag[MAG_W-1:COORD_W-FRAC_W]};
      num_low   = {diff_mag[COORD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      dir_neg   = -{dir[COORD_W-1], dir};
      dir_mag   = dir[COORD_W-1] ? dir_neg[COORD_W-1:0] : dir;
      overflow  = (rem_start >= dir_mag);

      trial     = {1'b0, rem_ff, quo_ff[COORD_W-1]} - {2'b00, dmag_ff};
      trial_ok  = !trial[COORD_W+1];

      if (neg_ff) begin
         t_sat = (quo_ff > COORD_MIN) ? COORD_MIN : -$signed(quo_ff);
      end else begin
         t_sat = quo_ff[COORD_W-1] ? COORD_MAX : $signed(quo_ff);
      end
      t_lo = (tfirst_ff < t_sat) ? tfirst_ff : t_sat;
      t_hi = (tfirst_ff < t_sat) ? t_sat : tfirst_ff;

      hit      = !miss_ff && (tmin_ff <= tmax_ff) && !tmax_ff[COORD_W-1];
      take     = hit && (!best_valid_ff || (tmin_ff < best_dist_ff));
      nb_valid = best_valid_ff || take;
      nb_dist  = take ? tmin_ff : best_dist_ff;
      nb_tag   = take ? box_ff.selection_tag : best_tag_ff;
   end

   always_comb begin
      state_in      = state_ff;
      box_in        = box_ff;
      axis_in       = axis_ff;
      side_in       = side_ff;
      miss_in       = miss_ff;
      tmin_in       = tmin_ff;
      tmax_in       = tmax_ff;
      tfirst_in     = tfirst_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dmag_in       = dmag_ff;
      neg_in        = neg_ff;
      count_in      = count_ff;
      best_dist_in  = best_dist_ff;
      best_tag_in   = best_tag_ff;
      best_valid_in = best_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      origin_in     = origin_ff;
      dir_in        = dir_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_in[0] = csr_wdata;
            CSR_ORIGIN_Y: origin_in[1] = csr_wdata;
            CSR_ORIGIN_Z: origin_in[2] = csr_wdata;
            CSR_DIR_X:    dir_in[0]    = csr_wdata;
            CSR_DIR_Y:    dir_in[1]    = csr_wdata;
            CSR_DIR_Z:    dir_in[2]    = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               box_in   = req_data;
               axis_in  = 2'd0;
               side_in  = 1'b0;
               miss_in  = 1'b0;
               tmin_in  = '0;
               tmax_in  = COORD_MAX;
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            if (sizes_bad) begin
               miss_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (dir == 0) begin
               if (outside) begin
                  miss_in  = 1'b1;
                  state_in = ST_FINISH;
               end else if (last_axis) begin
                  state_in = ST_FINISH;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               rem_in   = rem_start;
               quo_in   = overflow ? '1 : num_low;
               dmag_in  = dir_mag;
               neg_in   = diff[COORD_W+2] ^ dir[COORD_W-1];
               count_in = '0;
               state_in = overflow ? ST_UPDATE : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = trial_ok ? trial[COORD_W-1:0] : {rem_ff[COORD_W-2:0], quo_ff[COORD_W-1]};
            quo_in   = {quo_ff[COORD_W-2:0], trial_ok};
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(COORD_W - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!side_ff) begin
               tfirst_in = t_sat;
               side_in   = 1'b1;
               state_in  = ST_AXIS;
            end else begin
               tmin_in  = (t_lo > tmin_ff) ? t_lo : tmin_ff;
               tmax_in  = (t_hi < tmax_ff) ? t_hi : tmax_ff;
               side_in  = 1'b0;
               if (last_axis) begin
                  state_in = ST_FINISH;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_AXIS;
               end
            end
         end
         ST_FINISH: begin
            if (!box_ff.last_box) begin
               best_valid_in = nb_valid;
               best_dist_in  = nb_dist;
               best_tag_in   = nb_tag;
               state_in      = ST_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.hit_found        = nb_valid;
               rsp_data_in.nearest_tag      = nb_valid ? nb_tag : '0;
               rsp_data_in.nearest_distance = nb_valid ? nb_dist[DIST_W-1:0] : '0;
               best_valid_in                = 1'b0;
               best_dist_in                 = COORD_MAX;
               best_tag_in                  = '0;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      box_ff      <= box_in;
      tmin_ff     <= tmin_in;
      tmax_ff     <= tmax_in;
      tfirst_ff   <= tfirst_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dmag_ff     <= dmag_in;
      neg_ff      <= neg_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= 2'd0;
         side_ff       <= 1'b0;
         miss_ff       <= 1'b0;
         best_dist_ff  <= COORD_MAX;
         best_tag_ff   <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         origin_ff     <= '{default: '0};
         dir_ff        <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         side_ff       <= side_in;
         miss_ff       <= miss_in;
         best_dist_ff  <= best_dist_in;
         best_tag_ff   <= best_tag_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         origin_ff     <= origin_in;
         dir_ff        <= dir_in;
      end
   end

endmodule
